[src/zqlff_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// zqlff_pkg
// Types, opcode constants and decode helpers for the Q latch and flag fixup
// observer.
// ----------------------------------------------------------------------------
package zqlff_pkg;

	typedef enum logic [1:0] {
		OP_FETCH_BOUNDARY = 2'd0,
		OP_FETCH_INNER    = 2'd1,
		OP_INT_ACK        = 2'd2,
		OP_CLEAR          = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		PK_NONE       = 3'd0,
		PK_INDEXED    = 3'd1,
		PK_CB         = 3'd2,
		PK_ED         = 3'd3,
		PK_INDEXED_CB = 3'd4
	} prefix_kind_t;

	localparam logic [7:0]  PREFIX_DD    = 8'hdd;
	localparam logic [7:0]  PREFIX_FD    = 8'hfd;
	localparam logic [7:0]  PREFIX_ED    = 8'hed;
	localparam logic [7:0]  PREFIX_CB    = 8'hcb;
	localparam logic [7:0]  OPC_SCF      = 8'h37;
	localparam logic [7:0]  OPC_CCF      = 8'h3f;
	localparam logic [7:0]  OPC_INIR     = 8'hb2;
	localparam logic [7:0]  OPC_INDR     = 8'hba;
	localparam logic [7:0]  OPC_OTIR     = 8'hb3;
	localparam logic [7:0]  OPC_OTDR     = 8'hbb;
	localparam logic [7:0]  MASK_XY      = 8'h28;
	localparam logic [7:0]  MASK_REG8    = 8'hc7;
	localparam logic [7:0]  MASK_PAIR    = 8'hcf;
	localparam logic [15:0] WZ_ADD_INIR  = 16'h0101;
	localparam logic [15:0] WZ_ADD_INDR  = 16'h00ff;
	localparam logic [15:0] WZ_ADD_OTIR  = 16'h0001;
	localparam logic [15:0] WZ_ADD_OTDR  = 16'hffff;

	typedef struct packed {
		op_t         op;
		logic [7:0]  fetched_byte;
		logic [7:0]  last_opcode;
		logic [7:0]  flags_in;
		logic [7:0]  accumulator;
		logic [15:0] pair_bc;
		logic [1:0]  int_mode;
	} zqlff_in_t;

	typedef struct packed {
		logic [7:0]  flags_out;
		logic        flags_write;
		logic [15:0] wz_out;
		logic        wz_write;
		logic        q_out;
	} zqlff_out_t;

	// prefix tracking; CB, ED and DD-CB are sticky
	function automatic prefix_kind_t note_byte(input prefix_kind_t pk, input logic [7:0] b);
		prefix_kind_t r;
		r = pk;
		if (pk == PK_NONE || pk == PK_INDEXED) begin
			if (b == PREFIX_DD || b == PREFIX_FD)
				r = PK_INDEXED;
			else if (b == PREFIX_ED)
				r = PK_ED;
			else if (b == PREFIX_CB)
				r = (pk == PK_INDEXED) ? PK_INDEXED_CB : PK_CB;
		end
		return r;
	endfunction

	function automatic logic plain_alters_f(input logic [7:0] o);
		logic r;
		r = 1'b0;
		if (o[7:6] == 2'b10)
			r = 1'b1;
		if ((o & MASK_REG8) == 8'h04 || (o & MASK_REG8) == 8'h05)
			r = 1'b1;
		if ((o & MASK_PAIR) == 8'h09)
			r = 1'b1;
		case (o)
			8'h07, 8'h0f, 8'h17, 8'h1f, 8'h27, 8'h2f, 8'h37, 8'h3f,
			8'hc6, 8'hce, 8'hd6, 8'hde, 8'he6, 8'hee, 8'hf6, 8'hfe: r = 1'b1;
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic ext_alters_f(input logic [7:0] o);
		logic r;
		r = 1'b0;
		if ((o & MASK_REG8) == 8'h40 || (o & MASK_REG8) == 8'h44)
			r = 1'b1;
		if ((o & MASK_PAIR) == 8'h42 || (o & MASK_PAIR) == 8'h4a)
			r = 1'b1;
		case (o)
			8'h57, 8'h5f, 8'h67, 8'h6f,
			8'ha0, 8'ha1, 8'ha2, 8'ha3, 8'ha8, 8'ha9, 8'haa, 8'hab,
			8'hb0, 8'hb1, 8'hb2, 8'hb3, 8'hb8, 8'hb9, 8'hba, 8'hbb: r = 1'b1;
			default: ;
		endcase
		return r;
	endfunction

endpackage : zqlff_pkg
`default_nettype wire

[src/z80_q_latch_flag_fixup.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// z80_q_latch_flag_fixup
// Watches the core's fetch / acknowledge / clear events, tracks prefix kind
// and the Q latch, patches F bits 3 and 5 on SCF/CCF and rewrites WZ on the
// block I/O repeat instructions.
// ----------------------------------------------------------------------------
//  channel  | signals                          | transfer when
//  ---------+----------------------------------+----------------------------
//  item     | item_valid, item_ready, item     | item_valid & item_ready
//  result   | result_valid, result_ready,result| result_valid & result_ready
//
//  One event per cycle sustained while result_ready stays high; each event
//  passes the input register, then the result register. The decode and
//  state update sit between the two. Reset clears the tracking state and
//  both valid flags. A stalled result holds the input register; item_ready
//  drops only when both registers are full and result_ready is low.
// ----------------------------------------------------------------------------
module z80_q_latch_flag_fixup (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   item_valid,
	output logic                  item_ready,
	input  wire zqlff_pkg::zqlff_in_t item,
	output logic                  result_valid,
	input  wire                   result_ready,
	output zqlff_pkg::zqlff_out_t result
);
	import zqlff_pkg::*;

	zqlff_in_t    item_s1;
	logic         valid_s1;
	zqlff_out_t   result_q;
	logic         result_valid_q;

	logic         q_q;
	logic         in_instr_q;
	logic [7:0]   fas_q;
	prefix_kind_t prefix_q;

	logic         q_d;
	logic         in_instr_d;
	logic [7:0]   fas_d;
	prefix_kind_t prefix_d;
	zqlff_out_t   res_d;
	logic         adv_s1;

	assign adv_s1     = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid)
			item_s1 <= item;
	end

	// finish / start logic for the event in the input register
	always_comb begin
		logic [7:0] f;
		logic       alters;
		logic       plain;
		f          = item_s1.flags_in;
		q_d        = q_q;
		in_instr_d = in_instr_q;
		fas_d      = fas_q;
		prefix_d   = prefix_q;
		res_d      = '0;
		alters     = 1'b0;
		plain      = (prefix_q == PK_NONE) || (prefix_q == PK_INDEXED);

		if ((item_s1.op == OP_FETCH_BOUNDARY || item_s1.op == OP_INT_ACK) && in_instr_q) begin
			if (plain && (item_s1.last_opcode == OPC_SCF || item_s1.last_opcode == OPC_CCF)) begin
				f = (f & ~MASK_XY) |
				    ((q_q ? item_s1.accumulator : (fas_q | item_s1.accumulator)) & MASK_XY);
				res_d.flags_write = 1'b1;
			end
			if (prefix_q == PK_ED) begin
				unique case (item_s1.last_opcode)
					OPC_INIR: begin
						res_d.wz_out = item_s1.pair_bc + WZ_ADD_INIR;
						res_d.wz_write = 1'b1;
					end
					OPC_INDR: begin
						res_d.wz_out = item_s1.pair_bc + WZ_ADD_INDR;
						res_d.wz_write = 1'b1;
					end
					OPC_OTIR: begin
						res_d.wz_out = item_s1.pair_bc + WZ_ADD_OTIR;
						res_d.wz_write = 1'b1;
					end
					OPC_OTDR: begin
						res_d.wz_out = item_s1.pair_bc + WZ_ADD_OTDR;
						res_d.wz_write = 1'b1;
					end
					default: ;
				endcase
			end
			if (prefix_q == PK_CB || prefix_q == PK_INDEXED_CB)
				alters = !item_s1.last_opcode[7];
			else if (prefix_q == PK_ED)
				alters = ext_alters_f(item_s1.last_opcode);
			else
				alters = plain_alters_f(item_s1.last_opcode);
			q_d        = alters;
			in_instr_d = 1'b0;
		end

		unique case (item_s1.op)
			OP_FETCH_BOUNDARY: begin
				in_instr_d = 1'b1;
				fas_d      = f;
				prefix_d   = note_byte(PK_NONE, item_s1.fetched_byte);
			end
			OP_FETCH_INNER: begin
				prefix_d = note_byte(prefix_q, item_s1.fetched_byte);
			end
			OP_INT_ACK: begin
				q_d        = 1'b0;
				in_instr_d = 1'b0;
				prefix_d   = PK_NONE;
				// mode 0 executes the acknowledge byte as an opcode
				if (item_s1.int_mode == 2'd0) begin
					in_instr_d = 1'b1;
					fas_d      = f;
					prefix_d   = note_byte(PK_NONE, item_s1.fetched_byte);
				end
			end
			OP_CLEAR: begin
				q_d        = 1'b0;
				in_instr_d = 1'b0;
				fas_d      = '0;
				prefix_d   = PK_NONE;
			end
			default: ;
		endcase

		res_d.flags_out = f;
		res_d.q_out     = q_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q            <= 1'b0;
			in_instr_q     <= 1'b0;
			fas_q          <= '0;
			prefix_q       <= PK_NONE;
			result_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				q_q        <= q_d;
				in_instr_q <= in_instr_d;
				fas_q      <= fas_d;
				prefix_q   <= prefix_d;
			end
			if (adv_s1)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			result_q <= res_d;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	a_wz_excl_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.wz_write |-> !result.flags_write)
		else $error("WZ and F write-back in the same result");

	a_wz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.wz_write |-> result.wz_out == 16'h0000)
		else $error("WZ value present without write-back");

	a_q_matches: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> result.q_out == q_q)
		else $error("reported Q differs from the latch");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && item_s1.op == OP_CLEAR |=>
			!q_q && !in_instr_q && prefix_q == PK_NONE && fas_q == 8'h00)
		else $error("clear event left state behind");
`endif

endmodule : z80_q_latch_flag_fixup
`default_nettype wire
